/* sv/bfpsd_pkg.sv */
// Shared types and codes for the best-fit partition allocator with shortest-burst dispatch.
`timescale 1ns / 1ps

package bfpsd_pkg;

   // Configuration port geometry: eight capacity registers of 16 bits each.
   localparam int NUM_REGS    = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Request opcodes.
   localparam logic OP_ALLOC    = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   // Response status codes.
   localparam logic [1:0] STAT_GRANTED    = 2'd0;
   localparam logic [1:0] STAT_NOFIT      = 2'd1;
   localparam logic [1:0] STAT_DISPATCHED = 2'd2;
   localparam logic [1:0] STAT_EMPTY      = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  job_id;
      logic [15:0] job_size;
      logic [15:0] burst_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  partition;
      logic [7:0]  out_job;
      logic [15:0] out_burst;
      logic [15:0] leftover;
   } rsp_type;

   // Control from the sequencer to the running-minimum unit.
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

endpackage

/* sv/bfpsd_scan.sv */
// Running-minimum tracker that keeps the best eligible candidate of a sequential scan.
`timescale 1ns / 1ps

module bfpsd_scan #(
   parameter int KEY_W = 16,
   parameter int IDX_W = 3,
   parameter int PAY_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bfpsd_pkg::scan_ctl_type ctl,
   input  logic                    cand_ok,
   input  logic [IDX_W-1:0]        cand_idx,
   input  logic [KEY_W-1:0]        cand_key,
   input  logic [PAY_W-1:0]        cand_pay,
   output logic                    found,
   output logic [IDX_W-1:0]        best_idx,
   output logic [KEY_W-1:0]        best_key,
   output logic [PAY_W-1:0]        best_pay
);

   logic             found_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PAY_W-1:0] pay_ff;
   logic             take_in;

   // A strictly smaller key replaces the best, so the first of equal keys wins.
   assign take_in = ctl.step && cand_ok && (!found_ff || (cand_key < key_ff));

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         found_ff <= 1'b0;
      end else if (take_in) begin
         found_ff <= 1'b1;
      end
      if (take_in) begin
         idx_ff <= cand_idx;
         key_ff <= cand_key;
         pay_ff <= cand_pay;
      end
   end

   assign found    = found_ff;
   assign best_idx = idx_ff;
   assign best_key = key_ff;
   assign best_pay = pay_ff;

endmodule

/* sv/best_fit_partition_sjf_dispatch.sv */
// Top level of the best-fit fixed-partition allocator with shortest-burst dispatch.
`timescale 1ns / 1ps

// This block manages NUM_PARTS fixed memory partitions whose capacities are set through
// the csr_ write port (register i holds the capacity of partition i; zero makes the
// partition unusable, and writes to indexes at or above NUM_PARTS are dropped). An
// allocate transaction places its job in the smallest free partition that can hold it,
// taking the lowest index on ties, and answers granted with the leftover space or no fit;
// a refused job is not queued, so the requester retries. A dispatch transaction finds the
// resident job with the shortest burst time (lowest index on ties), frees its partition
// and returns the job and its burst, or reports that nothing is resident. From acceptance
// to a loaded response, the scan walks the job record memory and the capacity registers
// partition by partition through a single shared comparator, the last read settles into
// the comparator, and the result is committed. The next request can be accepted in the
// cycle after the commit. The block works on one request at a time; the response sits in
// an output register, so a new request is accepted while the previous response still
// waits to be taken, and a commit is held back only while that earlier response has not
// been taken yet. Capacities should be changed only while the block is idle. A resident
// job keeps its partition when that partition's capacity is rewritten.

module best_fit_partition_sjf_dispatch #(
   parameter int NUM_PARTS = 8,
   parameter int SIZE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bfpsd_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bfpsd_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic [bfpsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bfpsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int CNT_W = $clog2(NUM_PARTS + 1);
   localparam int KEY_W = (SIZE_BITS > 16) ? SIZE_BITS : 16;
   localparam int CSR_CMP_W = bfpsd_pkg::CSR_IDX_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_DONE
   } state_type;

   // One record per partition: the job that lives there and its burst time.
   typedef struct packed {
      logic [7:0]  job;
      logic [15:0] burst;
   } rec_type;

   state_type               state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic                    stg_vld_ff;
   logic [IDX_W-1:0]        stg_idx_ff;
   logic [NUM_PARTS-1:0]    busy_ff;
   bfpsd_pkg::req_type      req_ff;
   bfpsd_pkg::rsp_type      rsp_ff;
   logic                    rsp_valid_ff;
   logic [15:0]             size_ff [NUM_PARTS];

   rec_type                 mem [NUM_PARTS];
   rec_type                 rd_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;

   bfpsd_pkg::scan_ctl_type scan_ctl;
   logic                    cand_ok;
   logic [KEY_W-1:0]        cand_key;
   logic [7:0]              cand_pay;
   logic [KEY_W-1:0]        cap_key;
   logic [KEY_W-1:0]        need_key;
   logic                    best_found;
   logic [IDX_W-1:0]        best_idx;
   logic [KEY_W-1:0]        best_key;
   logic [7:0]              best_pay;

   logic                    accept;
   logic                    fire;
   logic                    is_alloc;
   bfpsd_pkg::rsp_type      rsp_in;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign fire      = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign is_alloc  = (req_ff.opcode == bfpsd_pkg::OP_ALLOC);

   // Capacity registers; only the low SIZE_BITS of a capacity take part in fitting.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PARTS; i++) begin
            size_ff[i] <= '0;
         end
      end else if (csr_we && ({1'b0, csr_index} < CSR_CMP_W'(NUM_PARTS))) begin
         size_ff[csr_index[IDX_W-1:0]] <= csr_wdata;
      end
   end

   // Job record memory: one write port for grants, one registered read port for the scan.
   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign mem_we  = fire && is_alloc && best_found;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[best_idx] <= '{job: req_ff.job_id, burst: req_ff.burst_time};
      end
      rd_ff <= mem[rd_addr];
   end

   // The stage register lines up the capacity and busy bit of a partition with its
   // record as it comes out of the memory's registered read port.
   assign cap_key  = KEY_W'(SIZE_BITS'(size_ff[stg_idx_ff]));
   assign need_key = KEY_W'(SIZE_BITS'(req_ff.job_size));

   always_comb begin
      if (is_alloc) begin
         cand_ok  = !busy_ff[stg_idx_ff] && (cap_key != '0) && (cap_key >= need_key);
         cand_key = cap_key;
         cand_pay = req_ff.job_id;
      end else begin
         cand_ok  = busy_ff[stg_idx_ff];
         cand_key = KEY_W'(rd_ff.burst);
         cand_pay = rd_ff.job;
      end
   end

   assign scan_ctl.clear = accept;
   assign scan_ctl.step  = stg_vld_ff;

   bfpsd_scan #(
      .KEY_W(KEY_W),
      .IDX_W(IDX_W),
      .PAY_W(8)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctl      (scan_ctl),
      .cand_ok  (cand_ok),
      .cand_idx (stg_idx_ff),
      .cand_key (cand_key),
      .cand_pay (cand_pay),
      .found    (best_found),
      .best_idx (best_idx),
      .best_key (best_key),
      .best_pay (best_pay)
   );

   // Response contents once the scan has seen every partition.
   always_comb begin
      rsp_in = '0;
      if (is_alloc) begin
         if (best_found) begin
            rsp_in.status    = bfpsd_pkg::STAT_GRANTED;
            rsp_in.partition = 3'(best_idx);
            rsp_in.out_job   = req_ff.job_id;
            rsp_in.leftover  = 16'(best_key - need_key);
         end else begin
            rsp_in.status = bfpsd_pkg::STAT_NOFIT;
         end
      end else begin
         if (best_found) begin
            rsp_in.status    = bfpsd_pkg::STAT_DISPATCHED;
            rsp_in.partition = 3'(best_idx);
            rsp_in.out_job   = best_pay;
            rsp_in.out_burst = 16'(best_key);
         end else begin
            rsp_in.status = bfpsd_pkg::STAT_EMPTY;
         end
      end
   end

   // Sequencer: accept, walk all partitions, let the last read settle, then commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         stg_vld_ff   <= 1'b0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !fire) begin
            rsp_valid_ff <= 1'b0;
         end
         stg_vld_ff <= (state_ff == S_SCAN);
         stg_idx_ff <= cnt_ff[IDX_W-1:0];
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  cnt_ff   <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(NUM_PARTS - 1)) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= rsp_in;
                  if (best_found) begin
                     busy_ff[best_idx] <= is_alloc;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* test/best_fit_partition_sjf_dispatch_tb.sv */
// Self-checking testbench for the best-fit partition allocator with shortest-burst dispatch.
`timescale 1ns / 1ps

module best_fit_partition_sjf_dispatch_tb;

   localparam int NUM_PARTS     = 8;
   localparam int BLOCK_LATENCY = NUM_PARTS + 3;
   localparam int NUM_PHASES    = 7;
   // The worst case per transaction adds block time, the longest receiver stall and the
   // longest sender gap, for each of ~750 transactions. The limit leaves a wide margin
   // over that.
   localparam int unsigned CYCLE_LIMIT = 400_000;

   typedef logic [15:0] cap_set_type [NUM_PARTS];

   // The ledger mirrors the partition table of the block. Every accepted request is
   // played against it at once, and the answer the block must give is queued until the
   // matching response transaction comes back.
   class partition_ledger;
      logic [15:0]        capacity   [NUM_PARTS];
      bit                 busy       [NUM_PARTS];
      logic [7:0]         held_job   [NUM_PARTS];
      logic [15:0]        held_burst [NUM_PARTS];
      bfpsd_pkg::rsp_type awaited    [$];
      int unsigned mismatches, checked;
      int unsigned granted, refused, dispatched, found_empty;

      function new();
         foreach (capacity[p]) begin
            capacity[p] = '0;
            busy[p]     = 1'b0;
         end
      endfunction

      function void set_capacity(int idx, logic [15:0] value);
         capacity[idx] = value;
      endfunction

      function void note_request(bfpsd_pkg::req_type r);
         bfpsd_pkg::rsp_type answer;
         int                 pick;
         logic [15:0]        pick_val;
         bit                 found;
         answer   = '0;
         pick     = 0;
         pick_val = '0;
         found    = 1'b0;
         if (r.opcode == bfpsd_pkg::OP_ALLOC) begin
            // Smallest free usable partition that holds the job; strict compare keeps
            // the lowest index on ties.
            for (int p = 0; p < NUM_PARTS; p++) begin
               if (!busy[p] && capacity[p] != 0 && capacity[p] >= r.job_size &&
                   (!found || capacity[p] < pick_val)) begin
                  found    = 1'b1;
                  pick     = p;
                  pick_val = capacity[p];
               end
            end
            if (found) begin
               busy[pick]       = 1'b1;
               held_job[pick]   = r.job_id;
               held_burst[pick] = r.burst_time;
               answer.status    = bfpsd_pkg::STAT_GRANTED;
               answer.partition = 3'(pick);
               answer.out_job   = r.job_id;
               answer.leftover  = pick_val - r.job_size;
               granted++;
            end else begin
               answer.status = bfpsd_pkg::STAT_NOFIT;
               refused++;
            end
         end else begin
            // Shortest burst among resident jobs, lowest index on ties.
            for (int p = 0; p < NUM_PARTS; p++) begin
               if (busy[p] && (!found || held_burst[p] < pick_val)) begin
                  found    = 1'b1;
                  pick     = p;
                  pick_val = held_burst[p];
               end
            end
            if (found) begin
               busy[pick]        = 1'b0;
               answer.status     = bfpsd_pkg::STAT_DISPATCHED;
               answer.partition  = 3'(pick);
               answer.out_job    = held_job[pick];
               answer.out_burst  = pick_val;
               dispatched++;
            end else begin
               answer.status = bfpsd_pkg::STAT_EMPTY;
               found_empty++;
            end
         end
         awaited.insert(awaited.size(), answer);
      endfunction

      function void compare_field(string field, logic [15:0] exp_v, logic [15:0] got_v);
         if (exp_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v,
                     got_v);
         end
      endfunction

      function void check_response(bfpsd_pkg::rsp_type got);
         bfpsd_pkg::rsp_type want;
         checked++;
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response, expected none, got 0x%0h", $time, got);
         end else begin
            want = awaited.pop_front();
            compare_field("status",    16'(want.status),    16'(got.status));
            compare_field("partition", 16'(want.partition), 16'(got.partition));
            compare_field("out_job",   16'(want.out_job),   16'(got.out_job));
            compare_field("out_burst", want.out_burst,      got.out_burst);
            compare_field("leftover",  want.leftover,       got.leftover);
         end
      endfunction
   endclass

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   bfpsd_pkg::req_type               req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   bfpsd_pkg::rsp_type               rsp_data;
   logic                             csr_we    = 1'b0;
   logic [bfpsd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bfpsd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   partition_ledger ledger = new();
   int unsigned     cycle_count = 0;

   // Sender burst state: transactions left in the current burst.
   int unsigned burst_left = 0;

   // Receiver stall pattern state.
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned hold_left  = 0;

   best_fit_partition_sjf_dispatch u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Hard stop in case the block hangs or drops a response.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timed out after %0d cycles with %0d responses outstanding.", cycle_count,
               ledger.awaited.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // Response side. Signals are sampled right after the edge, so they hold the values
   // the block saw at that edge. The ready pattern switches now and then between always
   // ready, random dropouts, long stalls and a fixed rhythm taken from the cycle counter.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         ledger.check_response(rsp_data);
      end
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(16, 96);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 9) < 7);
         end
         2: begin
            if (hold_left != 0) begin
               hold_left <= hold_left - 1;
            end else begin
               rsp_ready <= !rsp_ready;
               hold_left <= rsp_ready ? $urandom_range(2, 14) : $urandom_range(0, 2);
            end
         end
         default: begin
            rsp_ready <= cycle_count[1];
         end
      endcase
   end

   function automatic bfpsd_pkg::req_type make_request(logic op, logic [7:0] id,
                                                       logic [15:0] size,
                                                       logic [15:0] burst);
      bfpsd_pkg::req_type r;
      r.opcode     = op;
      r.job_id     = id;
      r.job_size   = size;
      r.burst_time = burst;
      return r;
   endfunction

   // Offers one request transaction and returns at the edge where it was taken. The
   // sender works in bursts; between bursts valid drops for a random gap, and some
   // bursts follow each other with no gap at all. Valid is never lowered here right
   // before being raised, so back-to-back transactions keep it high.
   task automatic drive_request(input bfpsd_pkg::req_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      ledger.note_request(item);
   endtask

   // Stops sending and waits until every queued answer has been collected. Every request
   // yields exactly one response, so the block is idle once the queue is empty; a few
   // extra cycles are added anyway.
   task automatic await_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all eight capacity registers, one per cycle, while the block is idle.
   task automatic load_capacities(input cap_set_type caps);
      for (int idx = 0; idx < NUM_PARTS; idx++) begin
         csr_we    <= 1'b1;
         csr_index <= bfpsd_pkg::CSR_IDX_W'(idx);
         csr_wdata <= caps[idx];
         @(posedge clock);
         ledger.set_capacity(idx, caps[idx]);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      cap_set_type        caps;
      bfpsd_pkg::req_type opening [$];
      bfpsd_pkg::req_type item;
      int unsigned        alloc_pct, roll, slack, pick, phase_items;
      logic [15:0]        target;

      // Synchronous reset from the start, then release.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With every capacity at its reset value of zero, nothing is resident and no
      // partition is usable, even for a zero-size job.
      drive_request(make_request(bfpsd_pkg::OP_DISPATCH, 8'hFF, 16'hFFFF, 16'hFFFF));
      drive_request(make_request(bfpsd_pkg::OP_ALLOC, 8'h00, 16'h0000, 16'h0000));
      await_idle();

      // Directed table: one unusable partition, one of the largest size, a one-unit
      // partition and three equal ones so that ties are exercised.
      caps = '{16'd100, 16'd50, 16'd50, 16'd0, 16'hFFFF, 16'd1, 16'd200, 16'd50};
      load_capacities(caps);
      opening = '{
         // A zero-size job fits the smallest usable partition, never the zero one.
         make_request(bfpsd_pkg::OP_ALLOC, 8'h01, 16'd0, 16'd7),
         // Largest job and zero burst.
         make_request(bfpsd_pkg::OP_ALLOC, 8'hFF, 16'hFFFF, 16'd0),
         // Three equal fits: lowest index first.
         make_request(bfpsd_pkg::OP_ALLOC, 8'h10, 16'd50, 16'd7),
         make_request(bfpsd_pkg::OP_ALLOC, 8'h11, 16'd40, 16'hFFFF),
         make_request(bfpsd_pkg::OP_ALLOC, 8'h12, 16'd50, 16'd7),
         make_request(bfpsd_pkg::OP_ALLOC, 8'h13, 16'd101, 16'd3),
         // Only the 100 partition is left among the large ones, so this is refused.
         make_request(bfpsd_pkg::OP_ALLOC, 8'h14, 16'd101, 16'd3),
         make_request(bfpsd_pkg::OP_ALLOC, 8'h15, 16'd100, 16'd9),
         // Every usable partition is taken now.
         make_request(bfpsd_pkg::OP_ALLOC, 8'h16, 16'd0, 16'd1),
         // Drain in burst order; equal bursts leave by index.
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         make_request(bfpsd_pkg::OP_DISPATCH, 8'h00, 16'd0, 16'd0),
         // Leave a job resident so the next reconfiguration hits a busy partition.
         make_request(bfpsd_pkg::OP_ALLOC, 8'hA5, 16'd1, 16'hFFFF)
      };
      foreach (opening[k]) drive_request(opening[k]);

      // Random phases, each under a different capacity table. Jobs stay resident across
      // reconfiguration, so busy partitions get rewritten regularly.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         await_idle();
         for (int p = 0; p < NUM_PARTS; p++) begin
            case (ph)
               0:       caps[p] = 16'hFFFF;
               1:       caps[p] = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(1, 4));
               2:       caps[p] = 16'($urandom_range(0, 65535));
               3:       caps[p] = (p == 0) ? 16'($urandom_range(1, 65535)) : caps[0];
               4:       caps[p] = ($urandom_range(0, 9) < 4) ? 16'd0
                                                             : 16'($urandom_range(1, 300));
               5:       caps[p] = 16'd0;
               default: caps[p] = 16'($urandom_range(0, 65535));
            endcase
         end
         load_capacities(caps);
         // The all-zero table only drains resident jobs, so it gets a short phase.
         phase_items = (ph == 5) ? 40 : ((ph == NUM_PHASES - 1) ? 140 : 110);
         alloc_pct = 50;
         for (int n = 0; n < phase_items; n++) begin
            // Shift the allocate/dispatch mix now and then so occupancy swings between
            // empty and full.
            if (n % 16 == 0) alloc_pct = $urandom_range(30, 75);
            item.opcode = ($urandom_range(0, 99) < alloc_pct) ? bfpsd_pkg::OP_ALLOC
                                                              : bfpsd_pkg::OP_DISPATCH;
            item.job_id = 8'($urandom_range(0, 255));
            // Sizes are mostly aimed at a real capacity: exact or slightly smaller fits,
            // slightly too large, plus full-range, tiny and zero sizes.
            pick   = $urandom_range(0, NUM_PARTS - 1);
            target = ledger.capacity[pick];
            slack  = $urandom_range(0, 3);
            roll   = $urandom_range(0, 99);
            if (roll < 25) begin
               item.job_size = 16'($urandom_range(0, 65535));
            end else if (roll < 60) begin
               item.job_size = (target > slack) ? target - 16'(slack) : 16'd0;
            end else if (roll < 75) begin
               item.job_size = (target > 16'd65532) ? 16'hFFFF
                                                    : target + 16'($urandom_range(1, 3));
            end else if (roll < 90) begin
               item.job_size = 16'($urandom_range(0, 15));
            end else begin
               item.job_size = 16'd0;
            end
            // Small bursts make ties and zero bursts common.
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               item.burst_time = 16'($urandom_range(0, 65535));
            end else if (roll < 80) begin
               item.burst_time = 16'($urandom_range(0, 3));
            end else begin
               item.burst_time = 16'hFFFF - 16'($urandom_range(0, 1));
            end
            drive_request(item);
         end
      end

      // Collect the last answers, then watch a while longer for stray responses.
      await_idle();
      repeat (2 * BLOCK_LATENCY) @(posedge clock);

      $display("Covered %0d transactions under %0d capacity tables: %0d granted, %0d refused,",
               ledger.checked, NUM_PHASES + 2, ledger.granted, ledger.refused);
      $display("%0d dispatched, %0d found nothing resident; %0d field mismatches.",
               ledger.dispatched, ledger.found_empty, ledger.mismatches);
      if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
